FILE: design/lbbc_pkg.sv
// Shared types and constants of the buffer cache tag engine.
package lbbc_pkg;
    localparam int SLOTS      = 32;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        CMD_GET     = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_PIN     = 3'd3,
        CMD_UNPIN   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT_SCAN,
        S_FREE_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

    // one slot as it travels round the ring
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic        valid;
        t_count      count;
        t_slot       age;
        t_slot       idx;
    } t_entry;

    // commands from the sequencer to every cell
    typedef struct packed {
        logic   shift;
        logic   upd;
        t_slot  upd_idx;
        logic   retag;
        logic   set_valid;
        logic   cnt_inc;
        logic   cnt_dec;
        logic   set_one;
        logic   promote;
        t_slot  prom_age;
        logic [7:0]  dev;
        logic [31:0] blk;
    } t_cell_ctl;
endpackage

FILE: design/lru_block_buffer_cache.sv
// Top level: sequencer and ring of slot cells of the buffer cache tag engine.
// Usage: one request word enters on i_valid/o_ready with cmd, device_id,
// block_number and slot_index; one result word leaves on o_valid/i_ready.
// Slots live in a ring of 32 cells that rotates one position per cycle while
// a search runs; the sequencer inspects the cell at the ring head each cycle.
// A get spends one full rotation on the tag search and, on a miss, a second
// rotation on the victim search, then one apply step; any other command goes
// straight to the apply step. The result word is registered in the apply
// state and offered on o_valid in the output state.
// One request is in flight at a time: the next request is taken only after
// the result word has left.
// Reset (synchronous, active low) clears every tag, valid mark and count and
// sets slot i to age 31-i. The result word is held until i_ready; no new
// request is taken while it waits.
module lru_block_buffer_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_slot_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_result_slot,
    output logic        o_tag_hit,
    output logic        o_read_request,
    output logic        o_write_request,
    output logic [7:0]  o_disk_device,
    output logic [31:0] o_disk_block,
    output logic [1:0]  o_status
);
    localparam int N = lbbc_pkg::SLOTS;

    lbbc_pkg::t_state    r_state, n_state;
    lbbc_pkg::t_cell_ctl ctl;
    lbbc_pkg::t_entry    ent [N];

    logic [2:0]  r_cmd;
    logic [7:0]  r_dev;
    logic [31:0] r_blk;
    logic [4:0]  r_sidx;
    logic [lbbc_pkg::SLOT_BITS:0] r_cnt;
    logic        r_found;
    lbbc_pkg::t_slot r_best, r_best_age;
    lbbc_pkg::t_entry r_sel;  // copy of the chosen slot
    logic        r_hit;

    // ring of cells; cell k takes from cell k-1
    for (genvar k = 0; k < N; k++) begin : g_cell
        lbbc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init_idx (lbbc_pkg::t_slot'(k)),
            .i_ctl      (ctl),
            .i_prev     (ent[(k + N - 1) % N]),
            .o_entry    (ent[k])
        );
    end

    lbbc_pkg::t_entry head;
    assign head = ent[N-1];
    logic scan_done;
    assign scan_done = (r_cnt == (lbbc_pkg::SLOT_BITS+1)'(N - 1));

    logic tag_eq, free_ok;
    assign tag_eq  = head.dev == r_dev && head.blk == r_blk &&
                     (!r_found || head.age < r_best_age);
    assign free_ok = head.count == '0 && (!r_found || head.age > r_best_age);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbbc_pkg::S_IDLE: if (i_valid) begin
                n_state = (i_cmd == 3'(lbbc_pkg::CMD_GET)) ? lbbc_pkg::S_HIT_SCAN
                                                           : lbbc_pkg::S_APPLY;
            end
            lbbc_pkg::S_HIT_SCAN: if (scan_done) begin
                n_state = (r_found || tag_eq) ? lbbc_pkg::S_APPLY : lbbc_pkg::S_FREE_SCAN;
            end
            lbbc_pkg::S_FREE_SCAN: if (scan_done) n_state = lbbc_pkg::S_APPLY;
            lbbc_pkg::S_APPLY: n_state = lbbc_pkg::S_OUT;
            lbbc_pkg::S_OUT: if (i_ready) n_state = lbbc_pkg::S_IDLE;
            default: n_state = lbbc_pkg::S_IDLE;
        endcase
    end

    // decisions taken in the apply cycle
    logic c_max, c_zero;
    assign c_max  = r_sel.count == lbbc_pkg::COUNT_MAX;
    assign c_zero = r_sel.count == '0;

    // cell commands
    always_comb begin
        ctl = '0;
        ctl.dev = r_dev;
        ctl.blk = r_blk;
        ctl.upd_idx = r_best;
        ctl.prom_age = r_sel.age;
        ctl.shift = (r_state == lbbc_pkg::S_HIT_SCAN) ||
                    (r_state == lbbc_pkg::S_FREE_SCAN);
        if (r_state == lbbc_pkg::S_APPLY) begin
            unique case (r_cmd)
                3'(lbbc_pkg::CMD_GET): if (r_found) begin
                    ctl.upd = 1'b1;
                    if (r_hit) begin
                        ctl.cnt_inc   = !c_max;
                        ctl.set_valid = !c_max;
                    end else begin
                        ctl.retag = 1'b1;
                        ctl.set_one = 1'b1;
                        ctl.set_valid = 1'b1;
                    end
                end
                3'(lbbc_pkg::CMD_PIN): begin
                    ctl.upd = 1'b1;
                    ctl.cnt_inc = !c_max;
                end
                3'(lbbc_pkg::CMD_RELEASE): begin
                    ctl.upd = 1'b1;
                    ctl.cnt_dec = !c_zero;
                    ctl.promote = r_sel.count == lbbc_pkg::t_count'(1);
                end
                3'(lbbc_pkg::CMD_UNPIN): begin
                    ctl.upd = 1'b1;
                    ctl.cnt_dec = !c_zero;
                end
                default: ctl.upd = 1'b0;
            endcase
        end
    end

    // result word formed in the apply cycle
    logic [4:0]  n_slot;
    logic        n_hit, n_rd, n_wr;
    logic [7:0]  n_ddev;
    logic [31:0] n_dblk;
    logic [1:0]  n_st;

    always_comb begin
        n_slot = r_best;
        n_hit  = 1'b0;
        n_rd   = 1'b0;
        n_wr   = 1'b0;
        n_ddev = '0;
        n_dblk = '0;
        n_st   = lbbc_pkg::ST_OK;
        unique case (r_cmd)
            3'(lbbc_pkg::CMD_GET): begin
                if (!r_found) begin
                    n_slot = '0;
                    n_st   = lbbc_pkg::ST_NOFREE;
                end else if (r_hit) begin
                    n_hit = 1'b1;
                    if (c_max) n_st = lbbc_pkg::ST_OVER;
                    else if (!r_sel.valid) begin
                        n_rd   = 1'b1;
                        n_ddev = r_sel.dev;
                        n_dblk = r_sel.blk;
                    end
                end else begin
                    n_rd   = 1'b1;
                    n_ddev = r_dev;
                    n_dblk = r_blk;
                end
            end
            3'(lbbc_pkg::CMD_WRITE): begin
                n_wr   = 1'b1;
                n_ddev = r_sel.dev;
                n_dblk = r_sel.blk;
            end
            3'(lbbc_pkg::CMD_PIN): if (c_max) n_st = lbbc_pkg::ST_OVER;
            3'(lbbc_pkg::CMD_RELEASE), 3'(lbbc_pkg::CMD_UNPIN):
                if (c_zero) n_st = lbbc_pkg::ST_UNDER;
            default: n_slot = r_sidx;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = r_state == lbbc_pkg::S_IDLE;
        o_valid = r_state == lbbc_pkg::S_OUT;
    end

    // entry for a direct slot command: slot s sits at its own index at rest
    lbbc_pkg::t_entry direct;
    assign direct = ent[i_slot_index];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbbc_pkg::S_IDLE;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                lbbc_pkg::S_IDLE: begin
                    r_cmd <= i_cmd; r_dev <= i_device_id;
                    r_blk <= i_block_number; r_sidx <= i_slot_index;
                    r_found <= 1'b0; r_cnt <= '0; r_hit <= 1'b0;
                    r_best <= i_slot_index; r_sel <= direct;
                    r_best_age <= '0;
                end
                lbbc_pkg::S_HIT_SCAN: begin
                    r_cnt <= scan_done ? '0 : r_cnt + 1'b1;
                    if (tag_eq) begin
                        r_found <= 1'b1; r_hit <= 1'b1;
                        r_best <= head.idx; r_best_age <= head.age; r_sel <= head;
                    end
                end
                lbbc_pkg::S_FREE_SCAN: begin
                    r_cnt <= scan_done ? '0 : r_cnt + 1'b1;
                    if (free_ok) begin
                        r_found <= 1'b1;
                        r_best <= head.idx; r_best_age <= head.age; r_sel <= head;
                    end
                end
                lbbc_pkg::S_APPLY: begin
                    o_result_slot   <= n_slot;
                    o_tag_hit       <= n_hit;
                    o_read_request  <= n_rd;
                    o_write_request <= n_wr;
                    o_disk_device   <= n_ddev;
                    o_disk_block    <= n_dblk;
                    o_status        <= n_st;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: design/lbbc_cell.sv
// One slot cell of the ring; hands its entry to the next cell every shift.
module lbbc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbbc_pkg::t_slot      i_init_idx,
    input  lbbc_pkg::t_cell_ctl  i_ctl,
    input  lbbc_pkg::t_entry     i_prev,
    output lbbc_pkg::t_entry     o_entry
);
    lbbc_pkg::t_entry r_e, n_e;

    always_comb begin
        n_e = i_ctl.shift ? i_prev : r_e;
        // ageing pass for a promotion touches every slot at once
        if (i_ctl.promote && r_e.age < i_ctl.prom_age) begin
            n_e.age = r_e.age + 1'b1;
        end
        if (i_ctl.upd && r_e.idx == i_ctl.upd_idx) begin
            if (i_ctl.retag) begin
                n_e.dev   = i_ctl.dev;
                n_e.blk   = i_ctl.blk;
                n_e.valid = 1'b0;
            end
            if (i_ctl.set_valid) n_e.valid = 1'b1;
            if (i_ctl.set_one)   n_e.count = lbbc_pkg::t_count'(1);
            if (i_ctl.cnt_inc)   n_e.count = r_e.count + 1'b1;
            if (i_ctl.cnt_dec)   n_e.count = r_e.count - 1'b1;
            if (i_ctl.promote)   n_e.age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.dev   <= '0;
            r_e.blk   <= '0;
            r_e.valid <= 1'b0;
            r_e.count <= '0;
            r_e.age   <= lbbc_pkg::t_slot'(lbbc_pkg::SLOTS - 1) - i_init_idx;
            r_e.idx   <= i_init_idx;
        end else begin
            r_e <= n_e;
        end
    end

    assign o_entry = r_e;
endmodule

FILE: verif/tb_lru_block_buffer_cache.sv
// Self-checking testbench of the buffer cache tag and replacement engine.
module tb_lru_block_buffer_cache;
    timeunit 1ns;
    timeprecision 1ps;

    // one result word as the block should present it
    typedef struct packed {
        logic [4:0]  slot;
        logic        hit;
        logic        rd;
        logic        wr;
        logic [7:0]  ddev;
        logic [31:0] dblk;
        logic [1:0]  st;
    } t_result;

    // cache policy predictor and store of expected result words
    class cache_scoreboard;
        logic [7:0]  dev_q [lbbc_pkg::SLOTS];
        logic [31:0] blk_q [lbbc_pkg::SLOTS];
        logic        vld_q [lbbc_pkg::SLOTS];
        int unsigned cnt_q [lbbc_pkg::SLOTS];
        int unsigned age_q [lbbc_pkg::SLOTS];
        t_result     pending [$];
        int          mismatches;

        function void clear();
            for (int i = 0; i < lbbc_pkg::SLOTS; i++) begin
                dev_q[i] = '0; blk_q[i] = '0; vld_q[i] = 1'b0;
                cnt_q[i] = 0; age_q[i] = unsigned'(lbbc_pkg::SLOTS - 1 - i);
            end
            pending = {};
            mismatches = 0;
        endfunction

        function void promote(int s);
            int unsigned old;
            old = age_q[s];
            for (int i = 0; i < lbbc_pkg::SLOTS; i++)
                if (age_q[i] < old) age_q[i]++;
            age_q[s] = 0;
        endfunction

        // note an accepted request word and predict its result
        function void note_request(logic [2:0] cmd, logic [7:0] dev, logic [31:0] blk,
                                   logic [4:0] idx);
            t_result r;
            bit found;
            int best;
            int unsigned best_age;
            r = '{slot: idx, hit: 0, rd: 0, wr: 0, ddev: 0, dblk: 0, st: lbbc_pkg::ST_OK};
            found = 0; best = 0; best_age = 0;
            if (cmd == lbbc_pkg::CMD_GET) begin
                for (int i = 0; i < lbbc_pkg::SLOTS; i++)
                    if (dev_q[i] == dev && blk_q[i] == blk &&
                        (!found || age_q[i] < best_age)) begin
                        found = 1; best = i; best_age = age_q[i];
                    end
                if (found) begin
                    r.hit = 1; r.slot = 5'(best);
                    if (cnt_q[best] >= lbbc_pkg::COUNT_MAX) r.st = lbbc_pkg::ST_OVER;
                    else cnt_q[best]++;
                end else begin
                    for (int i = 0; i < lbbc_pkg::SLOTS; i++)
                        if (cnt_q[i] == 0 && (!found || age_q[i] > best_age)) begin
                            found = 1; best = i; best_age = age_q[i];
                        end
                    if (!found) begin
                        r.slot = 0; r.st = lbbc_pkg::ST_NOFREE;
                    end else begin
                        r.slot = 5'(best);
                        dev_q[best] = dev; blk_q[best] = blk;
                        vld_q[best] = 0; cnt_q[best] = 1;
                    end
                end
                if (found && r.st == lbbc_pkg::ST_OK && !vld_q[r.slot]) begin
                    r.rd = 1; r.ddev = dev_q[r.slot]; r.dblk = blk_q[r.slot];
                    vld_q[r.slot] = 1;
                end
            end else if (cmd == lbbc_pkg::CMD_WRITE) begin
                r.wr = 1; r.ddev = dev_q[idx]; r.dblk = blk_q[idx];
            end else if (cmd == lbbc_pkg::CMD_PIN) begin
                if (cnt_q[idx] >= lbbc_pkg::COUNT_MAX) r.st = lbbc_pkg::ST_OVER;
                else cnt_q[idx]++;
            end else if (cmd == lbbc_pkg::CMD_RELEASE || cmd == lbbc_pkg::CMD_UNPIN) begin
                if (cnt_q[idx] == 0) r.st = lbbc_pkg::ST_UNDER;
                else begin
                    cnt_q[idx]--;
                    if (cmd == lbbc_pkg::CMD_RELEASE && cnt_q[idx] == 0) promote(idx);
                end
            end
            pending.push_back(r);
        endfunction

        // compare a result word with the oldest expectation
        function void check_result(t_result a);
            t_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word slot=%0d", a.slot);
                return;
            end
            e = pending.pop_front();
            if (a != e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp slot=%0d hit=%b rd=%b wr=%b dev=%h blk=%h st=%0d",
                              " / act slot=%0d hit=%b rd=%b wr=%b dev=%h blk=%h st=%0d"},
                             e.slot, e.hit, e.rd, e.wr, e.ddev, e.dblk, e.st,
                             a.slot, a.hit, a.rd, a.wr, a.ddev, a.dblk, a.st);
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic [2:0]  i_cmd = 0;
    logic [7:0]  i_device_id = 0;
    logic [31:0] i_block_number = 0;
    logic [4:0]  i_slot_index = 0;
    logic        o_ready, o_valid, o_tag_hit, o_read_request, o_write_request;
    logic [4:0]  o_result_slot;
    logic [7:0]  o_disk_device;
    logic [31:0] o_disk_block;
    logic [1:0]  o_status;

    cache_scoreboard sb;
    int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;

    lru_block_buffer_cache dut (.*);

    always #6 i_clk = ~i_clk;

    // result sampling at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_result_slot, o_tag_hit, o_read_request, o_write_request,
                              o_disk_device, o_disk_block, o_status});

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one request word and wait until it is taken
    task automatic send_word(logic [2:0] cmd, logic [7:0] dev, logic [31:0] blk,
                             logic [4:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid <= 1; i_cmd <= cmd; i_device_id <= dev;
        i_block_number <= blk; i_slot_index <= idx;
        // o_ready only moves at the rising edge, so it is settled here
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_request(cmd, dev, blk, idx);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // random word: mostly a small tag set so hits, pins and releases meet
    task automatic random_word();
        logic [2:0] c;
        logic [7:0] d;
        logic [31:0] b;
        int k;
        k = $urandom_range(99);
        c = (k < 40) ? lbbc_pkg::CMD_GET : (k < 50) ? lbbc_pkg::CMD_WRITE :
            (k < 75) ? lbbc_pkg::CMD_RELEASE : (k < 85) ? lbbc_pkg::CMD_PIN :
            (k < 95) ? lbbc_pkg::CMD_UNPIN : 3'($urandom_range(7));
        if ($urandom_range(9) < 8) begin
            d = 8'($urandom_range(3)); b = $urandom_range(40);
        end else begin
            d = 8'($urandom); b = $urandom;
        end
        send_word(c, d, b, 5'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: duplicate reset tags, extremes, every command
        send_word(lbbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0);
        send_word(lbbc_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd31);
        send_word(lbbc_pkg::CMD_WRITE, 8'h00, 32'h0, 5'd31);
        send_word(lbbc_pkg::CMD_WRITE, 8'h00, 32'h0, 5'd5);
        send_word(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd3);
        send_word(lbbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd3);
        send_word(lbbc_pkg::CMD_PIN, 8'hff, 32'hffff_ffff, 5'd3);
        send_word(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd3);
        send_word(3'd5, 8'hff, 32'hffff_ffff, 5'd17);
        send_word(3'd7, 8'h00, 32'h0, 5'd31);
        // pin one slot to its ceiling, then overflow on pin
        for (int i = 0; i < 256; i++) send_word(lbbc_pkg::CMD_PIN, 8'h00, 32'h0, 5'd9);
        send_word(lbbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0);
        for (int i = 0; i < 256; i++) send_word(lbbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd9);
        // fill every slot, then a miss finds no free buffer
        for (int i = 0; i < 33; i++) send_word(lbbc_pkg::CMD_GET, 8'h42, 32'(i + 100), 5'd0);
        for (int i = 0; i < 32; i++) send_word(lbbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'(i));
        drain();

        // random phases with differing idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 30; end
            endcase
            if (ph == 4) hold_cycles = 400;
            for (int n = 0; n < 232; n++) random_word();
            drain();
        end

        repeat (80) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
